// ----- rtl/itoa_pkg.sv -----
// Package for the integer-to-ASCII converter: item types, state encoding and
// character constants. Depends on nothing; imported by integer_to_ascii_radix_top.
`default_nettype none

package itoa_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int RADIX_WIDTH = 6;
	localparam int CHAR_WIDTH  = 7;

	localparam logic [RADIX_WIDTH-1:0] MIN_RADIX = 6'd2;
	localparam logic [RADIX_WIDTH-1:0] MAX_RADIX = 6'd36;
	localparam logic [RADIX_WIDTH-1:0] DEC_RADIX = 6'd10;
	localparam logic [RADIX_WIDTH-1:0] MAX_DEC_DIGIT = 6'd9;

	localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_A = 7'h61;
	localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'h2d;
	localparam logic [CHAR_WIDTH-1:0] CHAR_NUL   = 7'h00;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] number;
		logic [RADIX_WIDTH-1:0]        radix;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_WIDTH-1:0] character;
		logic                  last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_DIGIT,
		ST_SIGN,
		ST_READ,
		ST_EMIT,
		ST_TERM
	} state_t;

	function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [RADIX_WIDTH-1:0] d);
		logic [CHAR_WIDTH-1:0] d_ext;
		d_ext = {{(CHAR_WIDTH-RADIX_WIDTH){1'b0}}, d};
		if (d > MAX_DEC_DIGIT) begin
			return d_ext - 7'd10 + CHAR_LOW_A;
		end
		return d_ext + CHAR_ZERO;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/integer_to_ascii_radix_top.sv -----
// Integer-to-ASCII converter, radix 2 to 36, one restoring divider shared by all digits.
// Steps: load the item, then for each digit a division over the VALUE_WIDTH dividend bits (one quotient bit
// per cycle) and a digit store; then a sign if any, each digit read from store and emitted, and the NUL.
// One item at a time.
// Reset (arst_n low) returns the sequencer to idle with no item in flight.
// Depends on itoa_pkg.
`default_nettype none

module integer_to_ascii_radix_top (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire itoa_pkg::in_item_t in_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output itoa_pkg::out_item_t   out_data
);
	import itoa_pkg::*;

	localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
	localparam int ADDR_W = $clog2(VALUE_WIDTH);
	localparam int BIT_W  = $clog2(VALUE_WIDTH);
	localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(VALUE_WIDTH - 1);

	state_t                   state_q, state_d;
	logic [VALUE_WIDTH-1:0]   value_q, value_d;
	logic [RADIX_WIDTH-1:0]   radix_q, radix_d;
	logic [RADIX_WIDTH-1:0]   rem_q, rem_d;
	logic [BIT_W-1:0]         bit_cnt_q, bit_cnt_d;
	logic [CNT_W-1:0]         ndig_q, ndig_d;
	logic                     neg_q, neg_d;
	logic [RADIX_WIDTH-1:0]   rd_q;
	logic [RADIX_WIDTH-1:0]   digit_mem [VALUE_WIDTH];

	logic                     mem_we;
	logic                     mem_re;
	logic [CNT_W-1:0]         rd_cnt;
	logic [RADIX_WIDTH:0]     trial;
	logic                     trial_ge;
	logic [RADIX_WIDTH:0]     trial_diff;
	logic                     radix_ok;
	logic                     in_neg;

	// One restoring-division step: shift the next dividend bit into the remainder.
	assign trial      = {rem_q, value_q[VALUE_WIDTH-1]};
	assign trial_ge   = trial >= {1'b0, radix_q};
	assign trial_diff = trial - {1'b0, radix_q};
	assign rd_cnt     = ndig_q - CNT_W'(1);

	assign radix_ok = (in_data.radix >= MIN_RADIX) && (in_data.radix <= MAX_RADIX);
	assign in_neg   = (in_data.radix == DEC_RADIX) && in_data.number[VALUE_WIDTH-1];

	always_comb begin
		state_d   = state_q;
		value_d   = value_q;
		radix_d   = radix_q;
		rem_d     = rem_q;
		bit_cnt_d = bit_cnt_q;
		ndig_d    = ndig_q;
		neg_d     = neg_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		out_data.character = CHAR_NUL;
		out_data.last      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					radix_d   = in_data.radix;
					rem_d     = '0;
					bit_cnt_d = '0;
					ndig_d    = '0;
					neg_d     = in_neg;
					value_d   = in_neg ? VALUE_WIDTH'(-in_data.number)
					                   : VALUE_WIDTH'(in_data.number);
					state_d   = radix_ok ? ST_DIVIDE : ST_TERM;
				end
			end
			ST_DIVIDE: begin
				rem_d     = trial_ge ? trial_diff[RADIX_WIDTH-1:0] : trial[RADIX_WIDTH-1:0];
				value_d   = {value_q[VALUE_WIDTH-2:0], trial_ge};
				bit_cnt_d = bit_cnt_q + BIT_W'(1);
				if (bit_cnt_q == LAST_BIT) begin
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				// value_q now holds the quotient and rem_q the digit.
				mem_we    = 1'b1;
				ndig_d    = ndig_q + CNT_W'(1);
				rem_d     = '0;
				bit_cnt_d = '0;
				if (value_q == '0) begin
					state_d = neg_q ? ST_SIGN : ST_READ;
				end else begin
					state_d = ST_DIVIDE;
				end
			end
			ST_SIGN: begin
				out_valid          = 1'b1;
				out_data.character = CHAR_MINUS;
				if (out_ready) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				mem_re  = 1'b1;
				ndig_d  = rd_cnt;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid          = 1'b1;
				out_data.character = digit_to_ascii(rd_q);
				if (out_ready) begin
					state_d = (ndig_q == '0) ? ST_TERM : ST_READ;
				end
			end
			ST_TERM: begin
				out_valid     = 1'b1;
				out_data.last = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ndig_q  <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ndig_q  <= ndig_d;
			neg_q   <= neg_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q   <= value_d;
		radix_q   <= radix_d;
		rem_q     <= rem_d;
		bit_cnt_q <= bit_cnt_d;
	end

	// Digits are pushed least significant first and popped in reverse.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			digit_mem[ndig_q[ADDR_W-1:0]] <= rem_q;
		end
		if (mem_re) begin
			rd_q <= digit_mem[rd_cnt[ADDR_W-1:0]];
		end
	end

endmodule

`default_nettype wire

// ----- verif/tb_integer_to_ascii_radix_top.sv -----
// Testbench for integer_to_ascii_radix_top: sends numbers with a radix, predicts the
// character string of each, and checks every returned character in order.
// Depends on itoa_pkg and the integer_to_ascii_radix_top RTL.
`default_nettype none

module tb_integer_to_ascii_radix_top;
	import itoa_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 1200;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	out_item_t expected_chars[$];
	out_item_t want_char;
	int        error_count = 0;
	int        cycle_count = 0;
	int        ready_stall_left = 0;
	bit        idle_on = 1'b1;

	integer_to_ascii_radix_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Appends the characters that one number spells in the given radix.
	function automatic void spell_number(input logic signed [VALUE_WIDTH-1:0] num,
			input logic [RADIX_WIDTH-1:0] rdx);
		logic [VALUE_WIDTH-1:0] mag;
		logic [RADIX_WIDTH-1:0] digit;
		logic [CHAR_WIDTH-1:0]  glyphs[$];
		out_item_t              ch;
		if (rdx < MIN_RADIX || rdx > MAX_RADIX) begin
			ch.character = CHAR_NUL;
			ch.last = 1'b1;
			expected_chars.push_back(ch);
			return;
		end
		mag = num;
		// Only base ten prints a sign; other bases show the raw bit pattern.
		if (rdx == DEC_RADIX && num[VALUE_WIDTH-1]) begin
			mag = '0 - mag;
			glyphs.push_back(CHAR_MINUS);
		end
		do begin
			digit = mag % rdx;
			if (digit > MAX_DEC_DIGIT)
				glyphs.push_back(CHAR_WIDTH'(digit) - CHAR_WIDTH'(10) + CHAR_LOW_A);
			else
				glyphs.push_back(CHAR_WIDTH'(digit) + CHAR_ZERO);
			mag = mag / rdx;
		end while (mag != 0);
		// Digits were produced least significant first; emit the sign, then reverse.
		if (glyphs[0] == CHAR_MINUS && rdx == DEC_RADIX && num[VALUE_WIDTH-1]) begin
			ch.last = 1'b0;
			ch.character = CHAR_MINUS;
			expected_chars.push_back(ch);
			glyphs.pop_front();
		end
		while (glyphs.size() != 0) begin
			ch.character = glyphs.pop_back();
			ch.last = 1'b0;
			expected_chars.push_back(ch);
		end
		ch.character = CHAR_NUL;
		ch.last = 1'b1;
		expected_chars.push_back(ch);
	endfunction

	function automatic logic signed [VALUE_WIDTH-1:0] pick_number();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 99);
			2: return -int'($urandom_range(1, 5000));
			3: return 32'sh8000_0000 + int'($urandom_range(0, 3));
			4: return 32'sh7fff_ffff - int'($urandom_range(0, 3));
			default: return (32'sd1 <<< $urandom_range(0, 31)) - int'($urandom_range(0, 1));
		endcase
	endfunction

	task automatic send_item(input logic signed [VALUE_WIDTH-1:0] num,
			input logic [RADIX_WIDTH-1:0] rdx);
		in_item_t item;
		int       gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.number = num;
		item.radix = rdx;
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		spell_number(num, rdx);
	endtask

	task automatic wait_for_drain();
		while (expected_chars.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(0, 6'd10);
		send_item(0, 6'd2);
		send_item(0, 6'd36);
		send_item(32'sh7fff_ffff, 6'd10);
		send_item(32'sh8000_0000, 6'd10);
		send_item(-1, 6'd10);
		send_item(-1, 6'd2);
		send_item(32'sh8000_0000, 6'd2);
		send_item(-1, 6'd16);
		send_item(255, 6'd16);
		send_item(35, 6'd36);
		send_item(36, 6'd36);
		send_item(-1, 6'd36);
		send_item(32'sh7fff_ffff, 6'd36);
		send_item(123456789, 6'd8);
		send_item(7, 6'd3);
		send_item(-42, 6'd7);
		// Radix values outside 2..36 give only the terminator.
		send_item(1000, 6'd0);
		send_item(5, 6'd1);
		send_item(-1, 6'd37);
		send_item(9, 6'd63);
	endtask

	task automatic test_random_radix();
		repeat (280) send_item(pick_number(), 6'($urandom_range(2, 36)));
	endtask

	task automatic test_any_radix();
		repeat (60) send_item($urandom, 6'($urandom_range(0, 63)));
	endtask

	task automatic test_drain_pause();
		repeat (10) send_item(pick_number(), 6'($urandom_range(2, 36)));
		in_valid <= 1'b0;
		wait_for_drain();
		repeat (10) send_item(pick_number(), 6'($urandom_range(0, 40)));
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (80) send_item(pick_number(), 6'($urandom_range(2, 36)));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_chars.size() == 0) begin
				if (error_count < 10)
					$display("unexpected character %h last %b", out_data.character,
						out_data.last);
				error_count++;
			end else begin
				want_char = expected_chars.pop_front();
				if (out_data.character !== want_char.character ||
						out_data.last !== want_char.last) begin
					if (error_count < 10)
						$display("mismatch: expected char %h last %b, got char %h last %b",
							want_char.character, want_char.last,
							out_data.character, out_data.last);
					error_count++;
				end
			end
		end
		if (ready_stall_left > 0) begin
			ready_stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			ready_stall_left = $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_integer_to_ascii_radix_top NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_radix();
		test_any_radix();
		test_drain_pause();
		test_back_to_back();
		in_valid <= 1'b0;
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_chars.size() == 0)
			$display("tb_integer_to_ascii_radix_top OK");
		else
			$display("tb_integer_to_ascii_radix_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
